/* sv/mmcc_pkg.sv */
// Shared constants, codes and a helper function for the magic multiplier collision check.
package mmcc_pkg;

	localparam int MAX_MASK_BITS_DEF = 8;
	localparam int TABLE_ENTRIES_DEF = 32;

	localparam int WORD_W   = 64;
	localparam int HALF_W   = 32;
	localparam int INDEX_W  = 5;
	localparam int RIGHTS_W = 4;
	localparam int STATUS_W = 2;

	localparam logic [RIGHTS_W-1:0] RIGHTS_ALL = 4'hF;

	localparam logic [WORD_W-1:0] SQ_MASK_0 = 64'h0000_0000_0000_0090;
	localparam logic [WORD_W-1:0] SQ_MASK_1 = 64'h0000_0000_0000_0011;
	localparam logic [WORD_W-1:0] SQ_MASK_2 = 64'h9000_0000_0000_0000;
	localparam logic [WORD_W-1:0] SQ_MASK_3 = 64'h1100_0000_0000_0000;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_COLL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;

	function automatic logic [RIGHTS_W-1:0] rights_of(input logic [WORD_W-1:0] s);
		logic [RIGHTS_W-1:0] c;
		c = RIGHTS_ALL;
		if ((s & SQ_MASK_0) != '0) c[0] = 1'b0;
		if ((s & SQ_MASK_1) != '0) c[1] = 1'b0;
		if ((s & SQ_MASK_2) != '0) c[2] = 1'b0;
		if ((s & SQ_MASK_3) != '0) c[3] = 1'b0;
		return c;
	endfunction

endpackage

/* sv/mmcc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mmcc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/mmcc_mul.sv */
// Shared 32 by 32 bit multiplier with a registered product.
module mmcc_mul (
	input  logic                          clk,
	input  logic [mmcc_pkg::HALF_W-1:0]   op_a,
	input  logic [mmcc_pkg::HALF_W-1:0]   op_b,
	output logic [mmcc_pkg::WORD_W-1:0]   product
);

	logic [mmcc_pkg::WORD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= mmcc_pkg::WORD_W'(op_a) * mmcc_pkg::WORD_W'(op_b);
	end

	assign product = prod_q;

endmodule

/* sv/magic_multiplier_collision_check_core.sv */
// Top level of the magic multiplier collision check: sequencer, slot table and span scan.
// Steps: count the mask bits (overflow status past MAX_MASK_BITS), check each subset of the
// mask (stop on a collision), scan the table for the span, then load the output register.
// Throughput: one word at a time; each subset takes three passes through the shared
// multiplier plus a table read and a table update.
// Reset clears the sequencer, the occupancy mask, the slot valid bits and the output valid flag.
module magic_multiplier_collision_check_core #(
	parameter int MAX_MASK_BITS = mmcc_pkg::MAX_MASK_BITS_DEF,
	parameter int TABLE_ENTRIES = mmcc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mmcc_pkg::WORD_W-1:0]     occupancy_mask,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mmcc_pkg::WORD_W-1:0]     multiplier,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mmcc_pkg::STATUS_W-1:0]   status,
	output logic [mmcc_pkg::INDEX_W-1:0]    span
);

	localparam int IDXW = $clog2(TABLE_ENTRIES);
	localparam int CNTW = $clog2(MAX_MASK_BITS + 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_COUNT  = 9'b000000010,
		S_MUL0   = 9'b000000100,
		S_MUL1   = 9'b000001000,
		S_MUL2   = 9'b000010000,
		S_LOOK   = 9'b000100000,
		S_CHECK  = 9'b001000000,
		S_SCAN   = 9'b010000000,
		S_RESULT = 9'b100000000
	} state_t;

	state_t                          state_q;
	logic [mmcc_pkg::WORD_W-1:0]     mask_q;
	logic [mmcc_pkg::WORD_W-1:0]     mul_q;
	logic [mmcc_pkg::WORD_W-1:0]     subset_q;
	logic [mmcc_pkg::WORD_W-1:0]     tmp_q;
	logic [CNTW-1:0]                 cnt_q;
	logic [mmcc_pkg::HALF_W-1:0]     acc_q;
	logic [IDXW-1:0]                 idx_q;
	logic [TABLE_ENTRIES-1:0]        valid_q;
	logic [IDXW-1:0]                 scan_q;
	logic                            found_q;
	logic [IDXW-1:0]                 lo_q;
	logic [IDXW-1:0]                 hi_q;
	logic [mmcc_pkg::STATUS_W-1:0]   res_status_q;
	logic [mmcc_pkg::INDEX_W-1:0]    res_span_q;
	logic                            out_valid_q;
	logic [mmcc_pkg::STATUS_W-1:0]   status_q;
	logic [mmcc_pkg::INDEX_W-1:0]    span_q;

	logic [mmcc_pkg::HALF_W-1:0]     op_a;
	logic [mmcc_pkg::HALF_W-1:0]     op_b;
	logic [mmcc_pkg::WORD_W-1:0]     product;
	logic [mmcc_pkg::HALF_W-1:0]     hi_sum;
	logic [IDXW-1:0]                 look_idx;
	logic [mmcc_pkg::RIGHTS_W-1:0]   rights;
	logic [mmcc_pkg::RIGHTS_W-1:0]   rdata;
	logic                            collide;
	logic                            tbl_we;
	logic [mmcc_pkg::WORD_W-1:0]     next_subset;
	logic                            in_accept;
	logic                            out_free;
	logic                            scan_hit;
	logic                            found_nxt;
	logic [IDXW-1:0]                 lo_nxt;
	logic [IDXW-1:0]                 hi_nxt;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		unique case (state_q)
			S_MUL0: begin
				op_a = mul_q[mmcc_pkg::HALF_W-1:0];
				op_b = subset_q[mmcc_pkg::HALF_W-1:0];
			end
			S_MUL1: begin
				op_a = mul_q[mmcc_pkg::HALF_W-1:0];
				op_b = subset_q[mmcc_pkg::WORD_W-1:mmcc_pkg::HALF_W];
			end
			default: begin
				op_a = mul_q[mmcc_pkg::WORD_W-1:mmcc_pkg::HALF_W];
				op_b = subset_q[mmcc_pkg::HALF_W-1:0];
			end
		endcase
	end

	mmcc_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.product (product)
	);

	assign hi_sum   = acc_q + product[mmcc_pkg::HALF_W-1:0];
	assign look_idx = IDXW'(hi_sum[mmcc_pkg::HALF_W-1 -: mmcc_pkg::INDEX_W]);
	assign rights   = mmcc_pkg::rights_of(subset_q);
	assign collide  = valid_q[idx_q] && (rdata != rights);
	assign tbl_we   = (state_q == S_CHECK) && !collide;
	assign next_subset = (subset_q - mask_q) & mask_q;

	mmcc_ram #(
		.WIDTH (mmcc_pkg::RIGHTS_W),
		.DEPTH (TABLE_ENTRIES)
	) u_slot_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (idx_q),
		.wdata (rights),
		.raddr (look_idx),
		.rdata (rdata)
	);

	always_comb begin
		scan_hit  = valid_q[scan_q];
		found_nxt = found_q || scan_hit;
		lo_nxt    = (scan_hit && !found_q) ? scan_q : lo_q;
		hi_nxt    = scan_hit ? scan_q : hi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mask_q      <= '0;
			subset_q    <= '0;
			valid_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mask_q <= occupancy_mask;
			end
			if (out_valid_q && !out_stall && (state_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						mul_q    <= multiplier;
						tmp_q    <= mask_q;
						cnt_q    <= '0;
						subset_q <= '0;
						valid_q  <= '0;
						state_q  <= S_COUNT;
					end
				end
				S_COUNT: begin
					if (tmp_q == '0) begin
						state_q <= S_MUL0;
					end else if (cnt_q == CNTW'(MAX_MASK_BITS)) begin
						res_status_q <= mmcc_pkg::ST_OVER;
						res_span_q   <= '0;
						state_q      <= S_RESULT;
					end else begin
						tmp_q <= tmp_q & (tmp_q - 1'b1);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MUL0: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					acc_q   <= product[mmcc_pkg::WORD_W-1:mmcc_pkg::HALF_W];
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					acc_q   <= acc_q + product[mmcc_pkg::HALF_W-1:0];
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					idx_q   <= look_idx;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (collide) begin
						subset_q     <= '0;
						res_status_q <= mmcc_pkg::ST_COLL;
						res_span_q   <= '0;
						state_q      <= S_RESULT;
					end else begin
						valid_q[idx_q] <= 1'b1;
						subset_q       <= next_subset;
						if (next_subset == '0) begin
							scan_q  <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_MUL0;
						end
					end
				end
				S_SCAN: begin
					found_q <= found_nxt;
					lo_q    <= lo_nxt;
					hi_q    <= hi_nxt;
					if (scan_q == IDXW'(TABLE_ENTRIES - 1)) begin
						res_status_q <= mmcc_pkg::ST_OK;
						res_span_q   <= mmcc_pkg::INDEX_W'(hi_nxt - lo_nxt);
						state_q      <= S_RESULT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						span_q      <= res_span_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign span      = span_q;

	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESULT))
		else $error("Output word appeared without a finished check.");

	a_table_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (valid_q == '0))
		else $error("Slot valid bits were not cleared for a new word.");

	a_ok_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) && (res_status_q == mmcc_pkg::ST_OK) |-> found_q)
		else $error("Clean result reported with no occupied slot.");

	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) && (res_status_q != mmcc_pkg::ST_OK) |-> (res_span_q == '0))
		else $error("Span is nonzero on a failed check.");

endmodule
